// ===== hdl/min_heap_priority_queue_core_assert.svh =====
// assertion macros shared by the checker of min_heap_priority_queue_core
// no dependencies; include with the bare file name
`ifndef MIN_HEAP_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define MIN_HEAP_PRIORITY_QUEUE_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define MHPQ_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mhpq assertion failed");

// next-cycle implication, disabled while reset is low
`define MHPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mhpq assertion failed");

`endif

// ===== hdl/mhpq_pkg.sv =====
// types and constants of the min-heap priority queue
// used by mhpq_ctrl, mhpq_dp and mhpq_checker; no dependencies
package mhpq_pkg;

    localparam int KEY_W = 64;
    localparam int TAG_W = 8;
    localparam int ST_W  = 2;
    localparam int OCC_W = 5;

    // operation codes of an input item
    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    // one heap entry
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_entry;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        DP_NOP,
        DP_INS_START,
        DP_REJ_FULL,
        DP_REJ_EMPTY,
        DP_EXT_START,
        DP_EXT_LOAD,
        DP_UP_READ,
        DP_UP_STEP,
        DP_DN_READ,
        DP_DN_STEP,
        DP_EMIT
    } t_dp_op;

    // controller to datapath
    typedef struct packed {
        t_dp_op op;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic pos_zero;
        logic up_done;
        logic dn_done;
        logic out_free;
    } t_sts;

endpackage

// ===== hdl/min_heap_priority_queue_core.sv =====
// channel | valid       | stall        | payload
// in      | i_in_valid  | o_in_stall   | i_op, i_key, i_tag
// out     | o_out_valid | i_out_stall  | o_min_key, o_min_tag, o_status, o_occupancy
//
// one item at a time; a rejected item goes straight to its result; an insert climbs toward
// the root and an extract descends (at most log2(CAPACITY) levels), one level per
// read-then-compare step over the two-read, one-write entry memory.
// reset clears the entry count and output valid; the entry store needs no clearing.
// a new item is taken while an earlier result waits; it finishes once that result leaves.
//
// top level of the min-heap priority queue; depends on mhpq_pkg, mhpq_ctrl, mhpq_dp
module min_heap_priority_queue_core
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_op,
    input  logic [KEY_W-1:0] i_key,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [KEY_W-1:0] o_min_key,
    output logic [TAG_W-1:0] o_min_tag,
    output logic [ST_W-1:0]  o_status,
    output logic [OCC_W-1:0] o_occupancy
);

    t_cmd cmd;
    t_sts sts;

    // sequencer
    mhpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_busy     (o_in_stall)
    );

    // storage and compare logic
    mhpq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_key       (i_key),
        .i_tag       (i_tag),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_min_key   (o_min_key),
        .o_min_tag   (o_min_tag),
        .o_status    (o_status),
        .o_occupancy (o_occupancy)
    );

endmodule

// ===== hdl/mhpq_ctrl.sv =====
// controller state machine of the min-heap priority queue
// depends on mhpq_pkg; drives the command struct of mhpq_dp
module mhpq_ctrl
    import mhpq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_op,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXT_LD,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;

    // next state and command
    always_comb begin
        n_state   = r_state;
        o_cmd.op  = DP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_op == OP_INSERT) begin
                        if (i_sts.full) begin
                            o_cmd.op = DP_REJ_FULL;
                            n_state  = S_FIN;
                        end else begin
                            o_cmd.op = DP_INS_START;
                            n_state  = S_UP_RD;
                        end
                    end else begin
                        if (i_sts.empty) begin
                            o_cmd.op = DP_REJ_EMPTY;
                            n_state  = S_FIN;
                        end else begin
                            o_cmd.op = DP_EXT_START;
                            n_state  = S_EXT_LD;
                        end
                    end
                end
            end
            S_EXT_LD: begin
                o_cmd.op = DP_EXT_LOAD;
                n_state  = S_DN_RD;
            end
            S_UP_RD: begin
                o_cmd.op = DP_UP_READ;
                n_state  = i_sts.pos_zero ? S_FIN : S_UP_CMP;
            end
            S_UP_CMP: begin
                o_cmd.op = DP_UP_STEP;
                n_state  = i_sts.up_done ? S_FIN : S_UP_RD;
            end
            S_DN_RD: begin
                o_cmd.op = DP_DN_READ;
                n_state  = S_DN_CMP;
            end
            S_DN_CMP: begin
                o_cmd.op = DP_DN_STEP;
                n_state  = i_sts.dn_done ? S_FIN : S_DN_RD;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.op = DP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;

endmodule

// ===== hdl/mhpq_dp.sv =====
// datapath of the min-heap priority queue: entry memory, hole register,
// sift compare logic and output register; depends on mhpq_pkg
module mhpq_dp
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic [KEY_W-1:0] i_key,
    input  logic [TAG_W-1:0] i_tag,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output logic [KEY_W-1:0] o_min_key,
    output logic [TAG_W-1:0] o_min_tag,
    output logic [ST_W-1:0]  o_status,
    output logic [OCC_W-1:0] o_occupancy
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = IW + 2;

    // entry store, read data registered
    t_entry r_mem [CAPACITY];
    t_entry r_rd_a, r_rd_b;

    logic [CW-1:0] r_count, r_n;
    logic [IW-1:0] r_pos;
    t_entry        r_ent;

    // working result
    logic [KEY_W-1:0] r_res_key;
    logic [TAG_W-1:0] r_res_tag;
    logic [ST_W-1:0]  r_res_st;

    // output register
    logic             r_out_valid;
    logic [KEY_W-1:0] r_o_key;
    logic [TAG_W-1:0] r_o_tag;
    logic [ST_W-1:0]  r_o_st;
    logic [OCC_W-1:0] r_o_occ;

    logic [IW-1:0]       addr_a, addr_b, waddr, pos_m1, parent;
    logic [CW-1:0]       count_m1;
    logic                we;
    t_entry              wdata;
    logic [LW-1:0]       lc, rc, n_ext;
    logic                lc_ok, rc_ok, l_less, r_less, up_less;
    logic [KEY_W-1:0]    pick_key;
    logic [OCC_W+CW-1:0] occ_ext;

    // tree index arithmetic
    assign pos_m1   = r_pos - 1'b1;
    assign parent   = pos_m1 >> 1;
    assign count_m1 = r_count - 1'b1;
    assign lc       = LW'({r_pos, 1'b1});
    assign rc       = lc + 1'b1;
    assign n_ext    = LW'(r_n);
    assign lc_ok    = (lc < n_ext);
    assign rc_ok    = (rc < n_ext);

    // sift compares, signed keys
    assign up_less  = ($signed(r_ent.key) < $signed(r_rd_a.key));
    assign l_less   = lc_ok && ($signed(r_rd_a.key) < $signed(r_ent.key));
    assign pick_key = l_less ? r_rd_a.key : r_ent.key;
    assign r_less   = rc_ok && ($signed(r_rd_b.key) < $signed(pick_key));

    // memory port control
    always_comb begin
        addr_a = '0;
        addr_b = '0;
        we     = 1'b0;
        waddr  = r_pos;
        wdata  = r_ent;
        unique case (i_cmd.op)
            DP_EXT_START: begin
                addr_b = count_m1[IW-1:0];
            end
            DP_UP_READ: begin
                if (r_pos == '0) begin
                    we = 1'b1;
                end else begin
                    addr_a = parent;
                end
            end
            DP_UP_STEP: begin
                we = 1'b1;
                if (up_less) begin
                    wdata = r_rd_a;
                end
            end
            DP_DN_READ: begin
                addr_a = lc_ok ? lc[IW-1:0] : '0;
                addr_b = rc_ok ? rc[IW-1:0] : '0;
            end
            DP_DN_STEP: begin
                we = 1'b1;
                if (r_less) begin
                    wdata = r_rd_b;
                end else if (l_less) begin
                    wdata = r_rd_a;
                end
            end
            default: begin
            end
        endcase
    end

    // entry memory: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rd_a <= r_mem[addr_a];
        r_rd_b <= r_mem[addr_b];
    end

    // count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == DP_INS_START) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.op == DP_EXT_START) begin
                r_count <= count_m1;
            end
            if (i_cmd.op == DP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign occ_ext = {{OCC_W{1'b0}}, r_count};

    // hole position, moving entry and result
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_INS_START: begin
                r_ent.key <= i_key;
                r_ent.tag <= i_tag;
                r_pos     <= r_count[IW-1:0];
                r_res_key <= '0;
                r_res_tag <= '0;
                r_res_st  <= ST_OK;
            end
            DP_REJ_FULL: begin
                r_res_key <= '0;
                r_res_tag <= '0;
                r_res_st  <= ST_FULL;
            end
            DP_REJ_EMPTY: begin
                r_res_key <= '0;
                r_res_tag <= '0;
                r_res_st  <= ST_EMPTY;
            end
            DP_EXT_START: begin
                r_n      <= count_m1;
                r_res_st <= ST_OK;
            end
            DP_EXT_LOAD: begin
                r_res_key <= r_rd_a.key;
                r_res_tag <= r_rd_a.tag;
                r_ent     <= r_rd_b;
                r_pos     <= '0;
            end
            DP_UP_STEP: begin
                if (up_less) begin
                    r_pos <= parent;
                end
            end
            DP_DN_STEP: begin
                if (r_less) begin
                    r_pos <= rc[IW-1:0];
                end else if (l_less) begin
                    r_pos <= lc[IW-1:0];
                end
            end
            DP_EMIT: begin
                r_o_key <= r_res_key;
                r_o_tag <= r_res_tag;
                r_o_st  <= r_res_st;
                r_o_occ <= occ_ext[OCC_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // status to the controller
    assign o_sts.full     = (r_count >= CW'(CAPACITY));
    assign o_sts.empty    = (r_count == '0);
    assign o_sts.pos_zero = (r_pos == '0);
    assign o_sts.up_done  = !up_less;
    assign o_sts.dn_done  = !(l_less || r_less);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_min_key   = r_o_key;
    assign o_min_tag   = r_o_tag;
    assign o_status    = r_o_st;
    assign o_occupancy = r_o_occ;

endmodule

// ===== hdl/mhpq_checker.sv =====
// port-level checker of min_heap_priority_queue_core and its bind
// depends on mhpq_pkg and min_heap_priority_queue_core_assert.svh
`include "min_heap_priority_queue_core_assert.svh"

module mhpq_checker
    import mhpq_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic             i_op,
    input logic [KEY_W-1:0] i_key,
    input logic [TAG_W-1:0] i_tag,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic [KEY_W-1:0] o_min_key,
    input logic [TAG_W-1:0] o_min_tag,
    input logic [ST_W-1:0]  o_status,
    input logic [OCC_W-1:0] o_occupancy
);

    // an accepted item shows the block busy in the cycle after it is taken
    `MHPQ_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // an empty or full result carries no entry
    `MHPQ_ASSERT_NOW(a_reject_no_entry, i_clk, i_rst_n, o_out_valid && (o_status == ST_EMPTY || o_status == ST_FULL), o_min_key == '0 && o_min_tag == '0)

    // an extract on an empty heap leaves it empty
    `MHPQ_ASSERT_NOW(a_empty_occupancy, i_clk, i_rst_n, o_out_valid && o_status == ST_EMPTY, o_occupancy == '0)

    // a stalled result holds
    `MHPQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_min_key) && $stable(o_min_tag) && $stable(o_status) && $stable(o_occupancy))

endmodule

bind min_heap_priority_queue_core mhpq_checker u_mhpq_checker (.*);
